FILE: src/circle_segment_intersection_defines.svh
// assertion macros for circle_segment_intersection
`ifndef CIRCLE_SEGMENT_INTERSECTION_DEFINES_SVH
`define CIRCLE_SEGMENT_INTERSECTION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSI_ASSERT(lbl, prop, msg)
`define CSI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/csi_pkg.sv
package csi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int RW = COORD_WIDTH - 1;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int UW = PW;
  localparam int HW = UW / 2;
  localparam int MW = 2 * UW;
  localparam int KW = FRAC_BITS + 1;
  localparam int FW = SW + 2 * KW + 2;

  localparam logic [KW-1:0] ONE = KW'(1) << FRAC_BITS;

  typedef struct packed {
    logic empty;
    logic full;
    logic lo_en;
    logic hi_one;
    logic hi_zero;
  } csi_flags_t;

  typedef struct packed {
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] c;
    logic                 deg;
    logic                 f1pos;
    logic                 f1nn;
    logic                 g1neg;
    logic                 g1nn;
  } csi_geo_t;

  typedef struct packed {
    logic                 first;
    csi_flags_t           flags;
    logic [KW-1:0]        lo_k;
    logic                 lo_top;
    logic signed [FW-1:0] lo_f;
    logic signed [FW-1:0] lo_h;
    logic [KW-1:0]        hi_k;
    logic                 hi_top;
    logic signed [FW-1:0] hi_f;
    logic signed [FW-1:0] hi_h;
    logic signed [FW-1:0] u;
  } csi_cell_t;

endpackage

FILE: src/csi_if.sv
interface csi_in_if;
  import csi_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic        [COORD_WIDTH-2:0] circle_radius;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (output valid, center_x, center_y, circle_radius, start_x, start_y,
                  end_x, end_y, input ready);
  modport sink (input valid, center_x, center_y, circle_radius, start_x, start_y,
                end_x, end_y, output ready);
endinterface

interface csi_out_if;
  import csi_pkg::*;
  logic            valid;
  logic            ready;
  logic            is_empty;
  logic [KW-1:0]   lambda_low;
  logic [KW-1:0]   lambda_high;

  modport source (output valid, is_empty, lambda_low, lambda_high, input ready);
  modport sink (input valid, is_empty, lambda_low, lambda_high, output ready);
endinterface

FILE: src/csi_mul.sv
module csi_mul (
  input  logic                    clk,
  input  logic                    en,
  input  logic [csi_pkg::UW-1:0]  x,
  input  logic [csi_pkg::UW-1:0]  y,
  output logic [csi_pkg::MW-1:0]  p
);
  import csi_pkg::*;

  logic [2*HW-1:0] pll_r, plh_r, phl_r, phh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= x[HW-1:0]  * y[HW-1:0];
      plh_r <= x[HW-1:0]  * y[UW-1:HW];
      phl_r <= x[UW-1:HW] * y[HW-1:0];
      phh_r <= x[UW-1:HW] * y[UW-1:HW];
      p     <= MW'(pll_r) + (MW'(plh_r) << HW) + (MW'(phl_r) << HW)
               + (MW'(phh_r) << (2 * HW));
    end
  end
endmodule

FILE: src/csi_front.sv
module csi_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_v,
  input  logic signed [csi_pkg::COORD_WIDTH-1:0] center_x,
  input  logic signed [csi_pkg::COORD_WIDTH-1:0] center_y,
  input  logic        [csi_pkg::RW-1:0]       circle_radius,
  input  logic signed [csi_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [csi_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [csi_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [csi_pkg::COORD_WIDTH-1:0] end_y,
  output logic                                out_v,
  output csi_pkg::csi_cell_t                  out_dat
);
  import csi_pkg::*;

  localparam int NST = 7;

  logic [NST-1:0] v_r;

  logic signed [DW-1:0] sx_r, sy_r, vx_r, vy_r;
  logic [RW-1:0]        rad_r;
  logic                 deg2_r;
  logic signed [PW-1:0] pxx_r, pyy_r, qxx_r, qyy_r, bxx_r, byy_r, cxy_r, cyx_r;
  logic [2*RW-1:0]      rr2_r;
  logic signed [SW-1:0] a3_r, b3_r, c3_r, x3_r;
  logic [2*RW-1:0]      rr3_r;
  logic                 deg3_r;
  csi_geo_t             g4_r, g5_r, g6_r;
  logic [UW-1:0]        ma_r, mr_r, mc_r;
  logic [MW-1:0]        p_ar, p_cm;

  logic signed [SW+1:0] f1_s;
  logic signed [SW:0]   g1_s;
  logic signed [SW-1:0] xabs;
  csi_geo_t             g4_nxt;
  csi_flags_t           fl;
  logic                 disc_neg, c_le0, c_ge0, b_le0, b_ge0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_v};
    end
  end

  assign f1_s = (SW+2)'(a3_r) + ((SW+2)'(b3_r) <<< 1) + (SW+2)'(c3_r);
  assign g1_s = (SW+1)'(a3_r) + (SW+1)'(b3_r);
  assign xabs = x3_r[SW-1] ? -x3_r : x3_r;

  always_comb begin
    g4_nxt       = '0;
    g4_nxt.a     = a3_r;
    g4_nxt.b     = b3_r;
    g4_nxt.c     = c3_r;
    g4_nxt.deg   = deg3_r;
    g4_nxt.f1pos = !f1_s[SW+1] && (f1_s != '0);
    g4_nxt.f1nn  = !f1_s[SW+1];
    g4_nxt.g1neg = g1_s[SW];
    g4_nxt.g1nn  = !g1_s[SW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r   <= DW'(start_x) - DW'(center_x);
      sy_r   <= DW'(start_y) - DW'(center_y);
      vx_r   <= DW'(end_x) - DW'(start_x);
      vy_r   <= DW'(end_y) - DW'(start_y);
      rad_r  <= circle_radius;

      pxx_r  <= vx_r * vx_r;
      pyy_r  <= vy_r * vy_r;
      qxx_r  <= sx_r * sx_r;
      qyy_r  <= sy_r * sy_r;
      bxx_r  <= sx_r * vx_r;
      byy_r  <= sy_r * vy_r;
      cxy_r  <= sx_r * vy_r;
      cyx_r  <= sy_r * vx_r;
      rr2_r  <= rad_r * rad_r;
      deg2_r <= (vx_r == '0) && (vy_r == '0);

      a3_r   <= SW'(pxx_r) + SW'(pyy_r);
      b3_r   <= SW'(bxx_r) + SW'(byy_r);
      c3_r   <= SW'(qxx_r) + SW'(qyy_r) - $signed(SW'(rr2_r));
      x3_r   <= SW'(cxy_r) - SW'(cyx_r);
      rr3_r  <= rr2_r;
      deg3_r <= deg2_r;

      g4_r   <= g4_nxt;
      ma_r   <= a3_r[UW-1:0];
      mr_r   <= UW'(rr3_r);
      mc_r   <= xabs[UW-1:0];

      g5_r   <= g4_r;
      g6_r   <= g5_r;
    end
  end

  csi_mul u_mul_ar (.clk(clk), .en(en), .x(ma_r), .y(mr_r), .p(p_ar));
  csi_mul u_mul_cm (.clk(clk), .en(en), .x(mc_r), .y(mc_r), .p(p_cm));

  assign disc_neg = p_ar < p_cm;
  assign c_le0    = g6_r.c[SW-1] || (g6_r.c == '0);
  assign c_ge0    = !g6_r.c[SW-1];
  assign b_le0    = g6_r.b[SW-1] || (g6_r.b == '0);
  assign b_ge0    = !g6_r.b[SW-1];

  always_comb begin
    fl.full    = g6_r.deg && c_le0;
    fl.empty   = g6_r.deg ? !c_le0
               : (disc_neg || (!c_le0 && !b_le0) || (g6_r.f1pos && g6_r.g1neg));
    fl.lo_en   = c_ge0 && b_le0;
    fl.hi_one  = !(g6_r.f1nn && g6_r.g1nn);
    fl.hi_zero = c_ge0 && b_ge0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dat.first  <= 1'b1;
      out_dat.flags  <= fl;
      out_dat.lo_k   <= '0;
      out_dat.lo_top <= 1'b0;
      out_dat.lo_f   <= FW'(g6_r.c) <<< (2 * FRAC_BITS);
      out_dat.lo_h   <= FW'(g6_r.b) <<< (2 * FRAC_BITS + 1);
      out_dat.hi_k   <= '0;
      out_dat.hi_top <= 1'b0;
      out_dat.hi_f   <= FW'(g6_r.c) <<< (2 * FRAC_BITS);
      out_dat.hi_h   <= FW'(g6_r.b) <<< (2 * FRAC_BITS + 1);
      out_dat.u      <= FW'(g6_r.a) <<< (2 * FRAC_BITS);
    end
  end

  assign out_v = v_r[NST-1];
endmodule

FILE: src/csi_cell.sv
module csi_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  csi_pkg::csi_cell_t dat_i,
  output logic               vld_o,
  output csi_pkg::csi_cell_t dat_o
);
  import csi_pkg::*;

  logic signed [FW-1:0] fc_lo, hg_lo, fc_hi, hg_hi, u2;
  logic                 take_lo, take_hi;
  logic signed [FW-1:0] h_lo_sel, h_hi_sel;
  csi_cell_t            dat_nxt;

  assign u2    = $signed(dat_i.u) <<< 1;
  assign fc_lo = $signed(dat_i.lo_f) + $signed(dat_i.lo_h) + $signed(dat_i.u);
  assign hg_lo = $signed(dat_i.lo_h) + u2;
  assign fc_hi = $signed(dat_i.hi_f) + $signed(dat_i.hi_h) + $signed(dat_i.u);
  assign hg_hi = $signed(dat_i.hi_h) + u2;

  assign take_lo = !dat_i.lo_top && !fc_lo[FW-1] && (hg_lo[FW-1] || (hg_lo == '0));
  assign take_hi = !dat_i.hi_top && !(!fc_hi[FW-1] && !hg_hi[FW-1]);

  assign h_lo_sel = take_lo ? hg_lo : $signed(dat_i.lo_h);
  assign h_hi_sel = take_hi ? hg_hi : $signed(dat_i.hi_h);

  always_comb begin
    dat_nxt        = dat_i;
    dat_nxt.first  = 1'b0;
    dat_nxt.lo_k   = {dat_i.lo_k[KW-2:0], take_lo};
    dat_nxt.lo_top = dat_i.lo_top | (take_lo & dat_i.first);
    dat_nxt.lo_f   = take_lo ? fc_lo : dat_i.lo_f;
    dat_nxt.lo_h   = h_lo_sel >>> 1;
    dat_nxt.hi_k   = {dat_i.hi_k[KW-2:0], take_hi};
    dat_nxt.hi_top = dat_i.hi_top | (take_hi & dat_i.first);
    dat_nxt.hi_f   = take_hi ? fc_hi : dat_i.hi_f;
    dat_nxt.hi_h   = h_hi_sel >>> 1;
    dat_nxt.u      = $signed(dat_i.u) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_o <= dat_nxt;
    end
  end
endmodule

FILE: src/circle_segment_intersection.sv
// Throughput: one word per cycle while the skid register is empty;
// 7 front stages, then one cell per result bit.
// The output register plus one skid register let a word enter while a result waits.
// Reset: synchronous, active low; clears all valid bits, payload is not cleared.
`include "circle_segment_intersection_defines.svh"

module circle_segment_intersection (
  input  logic  clk,
  input  logic  rst_n,
  csi_in_if.sink    in_ch,
  csi_out_if.source out_ch
);
  import csi_pkg::*;

  logic               en;
  logic [KW:0]        cvld;
  csi_cell_t          cdat [KW+1];

  logic               res_v;
  logic               res_empty;
  logic [KW-1:0]      res_lo, res_hi;
  csi_cell_t          last;

  logic               out_v_r, skid_v_r;
  logic               out_e_r, skid_e_r;
  logic [KW-1:0]      out_lo_r, out_hi_r, skid_lo_r, skid_hi_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  csi_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_ch.valid),
    .center_x(in_ch.center_x), .center_y(in_ch.center_y),
    .circle_radius(in_ch.circle_radius),
    .start_x(in_ch.start_x), .start_y(in_ch.start_y),
    .end_x(in_ch.end_x), .end_y(in_ch.end_y),
    .out_v(cvld[0]), .out_dat(cdat[0])
  );

  for (genvar i = 0; i < KW; i++) begin : g_cell
    csi_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(cvld[i]), .dat_i(cdat[i]),
      .vld_o(cvld[i+1]), .dat_o(cdat[i+1])
    );
  end

  assign last  = cdat[KW];
  assign res_v = cvld[KW] && en;

  always_comb begin
    res_empty = 1'b0;
    res_lo    = last.flags.lo_en ? last.lo_k : '0;
    if (last.flags.hi_one) begin
      res_hi = ONE;
    end else if (last.flags.hi_zero) begin
      res_hi = '0;
    end else begin
      res_hi = KW'(last.hi_k + 1'b1);
    end
    if (last.flags.empty) begin
      res_empty = 1'b1;
      res_lo    = '0;
      res_hi    = '0;
    end else if (last.flags.full) begin
      res_lo = '0;
      res_hi = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_v;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_e_r  <= skid_e_r;
        out_lo_r <= skid_lo_r;
        out_hi_r <= skid_hi_r;
      end else begin
        out_e_r  <= res_empty;
        out_lo_r <= res_lo;
        out_hi_r <= res_hi;
      end
    end else if (res_v) begin
      skid_e_r  <= res_empty;
      skid_lo_r <= res_lo;
      skid_hi_r <= res_hi;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.is_empty    = out_e_r;
  assign out_ch.lambda_low  = out_lo_r;
  assign out_ch.lambda_high = out_hi_r;

  `CSI_ASSERT(a_skid_needs_out, skid_v_r |-> out_v_r, "skid word without output word")
  `CSI_ASSERT(a_skid_on_stall, $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready), "skid filled without stall")
  `CSI_ASSERT(a_empty_zero, (out_v_r && out_e_r) |-> (out_lo_r == '0 && out_hi_r == '0), "empty word with nonzero range")
  `CSI_ASSERT(a_range, out_v_r |-> (out_lo_r <= ONE && out_hi_r <= ONE), "range above one")
endmodule
